// ===== design/stci_pkg.sv =====
// Shared constants for the cubic-interpolated sine table core.
package stci_pkg;

  // Default configuration
  localparam int STCI_TABLE_DEPTH  = 2048;
  localparam int STCI_PHASE_WIDTH  = 32;
  localparam int STCI_SAMPLE_WIDTH = 16;

  // Fraction bits kept for the interpolation and rounding shift of each step
  localparam int STCI_FRAC_WIDTH = 16;
  localparam int STCI_RND_SHIFT  = 16;

  // pi/2 in Q2.30, used to build the table contents at elaboration
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Divisors (2n)(2n+1) of the odd Taylor terms of sin(x)
  localparam longint unsigned SINE_TERM_DIV [7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

endpackage

// ===== design/sine_table_cubic_interpolator_core.sv =====
// Sine table lookup with cubic interpolation: top level.
// valid_o travels with each transaction through the pipeline, one valid bit per register stage.
// Throughput: one transaction per cycle over seven register stages (index split, table
// read, differences, three Horner multiply-add stages, rounding and saturation).
// busy stays low: the pipeline never stalls, since the receiver cannot hold results off.
// Reset clears the valid bits only; the sine table is a constant built at elaboration.
module sine_table_cubic_interpolator_core
  import stci_pkg::*;
#(
  parameter int TABLE_DEPTH  = STCI_TABLE_DEPTH,
  parameter int PHASE_WIDTH  = STCI_PHASE_WIDTH,
  parameter int SAMPLE_WIDTH = STCI_SAMPLE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [PHASE_WIDTH-1:0]         phase_i,
  output logic                           valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] sample_o
);

  localparam int IW    = $clog2(TABLE_DEPTH);
  localparam int PW    = PHASE_WIDTH;
  localparam int SW    = SAMPLE_WIDTH;
  localparam int TW    = STCI_FRAC_WIDTH;
  localparam int CW    = SW + 4;   // p, q, r differences
  localparam int HW    = SW + 23;  // Horner accumulator
  localparam int HPW   = HW + TW + 1;
  localparam int Stages = 7;

  localparam bit DepthPow2 = (TABLE_DEPTH == (1 << IW));
  localparam logic [IW:0]   DepthW   = (IW + 1)'(TABLE_DEPTH);
  localparam logic [IW-1:0] LastIdx  = IW'(TABLE_DEPTH - 1);
  localparam longint unsigned DepthU = TABLE_DEPTH;
  localparam longint AmpMax = (longint'(1) <<< (SW - 1)) - 1;

  localparam logic signed [HPW-1:0] RndHalfP = HPW'(2 ** (STCI_RND_SHIFT - 1));
  localparam logic signed [HW-1:0]  RndHalfH = HW'(2 ** (STCI_RND_SHIFT - 1));
  localparam logic signed [HW-1:0]  SatMax   = HW'(AmpMax);
  localparam logic signed [HW-1:0]  SatMin   = HW'(-AmpMax - 1);

  typedef logic signed [SW-1:0] rom_t [TABLE_DEPTH];

  // One table entry: folded angle, odd Taylor series in Q2.30, scaled to amplitude
  function automatic logic signed [SW-1:0] sine_entry(longint i);
    longint            d;
    longint            k;
    longint            m;
    bit                neg;
    longint unsigned   um;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   mag;
    longint            s;
    longint            r;
    d = TABLE_DEPTH;
    k = 4 * i;
    if (k <= d) begin
      m = k;
    end else if (k <= 3 * d) begin
      m = 2 * d - k;
    end else begin
      m = k - 4 * d;
    end
    neg  = (m < 0);
    um   = neg ? longint'(-m) : longint'(m);
    x    = (HALF_PI_Q30 * um + DepthU / 2) / DepthU;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / SINE_TERM_DIV[n-1];
      if ((n % 2) == 1) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    if (s > (longint'(1) <<< 30)) begin
      s = longint'(1) <<< 30;
    end
    mag = (longint'(s) * AmpMax + (longint'(1) <<< 29)) >>> 30;
    r   = neg ? -longint'(mag) : longint'(mag);
    return SW'(r);
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      rom[i] = sine_entry(longint'(i));
    end
    return rom;
  endfunction

  // Two copies of the table, each read at two addresses per cycle
  localparam rom_t RomA = build_rom();
  localparam rom_t RomB = build_rom();

  // The pipeline takes a transaction every cycle
  assign busy = 1'b0;

  logic [Stages-1:0] valid_q;

  // Stage 1: split phase into table index and 16-bit fraction
  logic [PW+IW-1:0] scaled;
  if (DepthPow2) begin : g_shift
    assign scaled = {{IW{1'b0}}, phase_i} << IW;
  end else begin : g_mul
    assign scaled = {{IW{1'b0}}, phase_i} * (PW + IW)'(TABLE_DEPTH);
  end

  logic [IW-1:0] idx1_q;
  logic [TW-1:0] t1_q;

  always_ff @(posedge clk_i) begin
    idx1_q <= scaled[PW +: IW];
    t1_q   <= scaled[PW-1 -: TW];
  end

  // Stage 2: neighbor addresses with wrap, registered table reads
  logic [IW:0]   idx_ext;
  logic [IW:0]   sum_p1;
  logic [IW:0]   sum_p2;
  logic [IW-1:0] addr_m1;
  logic [IW-1:0] addr_p1;
  logic [IW-1:0] addr_p2;

  always_comb begin
    idx_ext = {1'b0, idx1_q};
    sum_p1  = idx_ext + (IW + 1)'(1);
    sum_p2  = idx_ext + (IW + 1)'(2);
    addr_m1 = (idx1_q == '0) ? LastIdx : idx1_q - IW'(1);
    addr_p1 = (sum_p1 >= DepthW) ? IW'(sum_p1 - DepthW) : IW'(sum_p1);
    addr_p2 = (sum_p2 >= DepthW) ? IW'(sum_p2 - DepthW) : IW'(sum_p2);
  end

  logic signed [SW-1:0] v0_q, v1_q, v2_q, v3_q;
  logic [TW-1:0]        t2_q;

  always_ff @(posedge clk_i) begin
    v0_q <= RomA[addr_m1];
    v1_q <= RomA[idx1_q];
    t2_q <= t1_q;
  end

  always_ff @(posedge clk_i) begin
    v2_q <= RomB[addr_p1];
    v3_q <= RomB[addr_p2];
  end

  // Stage 3: cubic coefficients
  logic signed [CW-1:0] d01;
  logic signed [CW-1:0] p_d;
  logic signed [CW-1:0] q_d;
  logic signed [CW-1:0] r_d;

  always_comb begin
    d01 = CW'(v0_q) - CW'(v1_q);
    p_d = (CW'(v3_q) - CW'(v2_q)) - d01;
    q_d = d01 - p_d;
    r_d = CW'(v2_q) - CW'(v0_q);
  end

  logic signed [CW-1:0] p3_q, q3_q, r3_q;
  logic signed [SW-1:0] v13_q;
  logic [TW-1:0]        t3_q;

  always_ff @(posedge clk_i) begin
    p3_q  <= p_d;
    q3_q  <= q_d;
    r3_q  <= r_d;
    v13_q <= v1_q;
    t3_q  <= t2_q;
  end

  // Stage 4: h = rnd(P*2^16 * t) + Q*2^16
  logic signed [TW:0]   t3s;
  logic signed [HW-1:0] h0;
  logic signed [HPW-1:0] prod4;
  logic signed [HW-1:0] h4_d;

  always_comb begin
    t3s   = {1'b0, t3_q};
    h0    = HW'(p3_q) <<< STCI_RND_SHIFT;
    prod4 = HPW'(h0) * HPW'(t3s);
    h4_d  = HW'((prod4 + RndHalfP) >>> STCI_RND_SHIFT) + (HW'(q3_q) <<< STCI_RND_SHIFT);
  end

  logic signed [HW-1:0] h4_q;
  logic signed [CW-1:0] r4_q;
  logic signed [SW-1:0] v14_q;
  logic [TW-1:0]        t4_q;

  always_ff @(posedge clk_i) begin
    h4_q  <= h4_d;
    r4_q  <= r3_q;
    v14_q <= v13_q;
    t4_q  <= t3_q;
  end

  // Stage 5: h = rnd(h * t) + R*2^16
  logic signed [TW:0]    t4s;
  logic signed [HPW-1:0] prod5;
  logic signed [HW-1:0]  h5_d;

  always_comb begin
    t4s   = {1'b0, t4_q};
    prod5 = HPW'(h4_q) * HPW'(t4s);
    h5_d  = HW'((prod5 + RndHalfP) >>> STCI_RND_SHIFT) + (HW'(r4_q) <<< STCI_RND_SHIFT);
  end

  logic signed [HW-1:0] h5_q;
  logic signed [SW-1:0] v15_q;
  logic [TW-1:0]        t5_q;

  always_ff @(posedge clk_i) begin
    h5_q  <= h5_d;
    v15_q <= v14_q;
    t5_q  <= t4_q;
  end

  // Stage 6: h = rnd(h * t) + S*2^16
  logic signed [TW:0]    t5s;
  logic signed [HPW-1:0] prod6;
  logic signed [HW-1:0]  h6_d;

  always_comb begin
    t5s   = {1'b0, t5_q};
    prod6 = HPW'(h5_q) * HPW'(t5s);
    h6_d  = HW'((prod6 + RndHalfP) >>> STCI_RND_SHIFT) + (HW'(v15_q) <<< STCI_RND_SHIFT);
  end

  logic signed [HW-1:0] h6_q;

  always_ff @(posedge clk_i) begin
    h6_q <= h6_d;
  end

  // Stage 7: round to sample units and saturate
  logic signed [HW-1:0] res;
  logic signed [HW-1:0] sat;

  always_comb begin
    res = (h6_q + RndHalfH) >>> STCI_RND_SHIFT;
    if (res > SatMax) begin
      sat = SatMax;
    end else if (res < SatMin) begin
      sat = SatMin;
    end else begin
      sat = res;
    end
  end

  logic signed [SW-1:0] sample_q;

  always_ff @(posedge clk_i) begin
    sample_q <= SW'(sat);
  end

  // Valid bits travel with each transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[Stages-2:0], start & ~busy};
    end
  end

  assign valid_o  = valid_q[Stages-1];
  assign sample_o = sample_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the cubic-interpolated sine table core.
module testbench
  import stci_pkg::*;
;

  localparam int     Depth     = STCI_TABLE_DEPTH;
  localparam int     IdxWidth  = $clog2(STCI_TABLE_DEPTH);
  localparam int     PhWidth   = STCI_PHASE_WIDTH;
  localparam int     SmpWidth  = STCI_SAMPLE_WIDTH;
  localparam int     FracWidth = STCI_FRAC_WIDTH;
  localparam longint SampleMax = (64'sd1 <<< (SmpWidth - 1)) - 1;
  localparam longint SampleMin = -(64'sd1 <<< (SmpWidth - 1));
  localparam int     IdlePct   = 21;
  localparam int     Latency   = 7;

  logic                       clk_i   = 1'b0;
  logic                       rst_ni  = 1'b0;
  logic                       start   = 1'b0;
  logic [PhWidth-1:0]         phase_i = '0;
  logic                       busy;
  logic                       valid_o;
  logic signed [SmpWidth-1:0] sample_o;

  longint                     sine_lut [Depth];
  logic signed [SmpWidth-1:0] expected_samples [$];
  int                         mismatch_count = 0;
  bit                         no_idle = 1'b0;

  always #4 clk_i = ~clk_i;

  sine_table_cubic_interpolator_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .phase_i  (phase_i),
    .valid_o  (valid_o),
    .sample_o (sample_o)
  );

  // Sine table contents: quarter-wave fold, Taylor series in Q2.30, scale to amplitude
  initial begin : build_sine_lut
    longint          m;
    longint          s;
    longint unsigned um;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned mag;
    longint          k;
    for (int i = 0; i < Depth; i++) begin
      k = 4 * i;
      if (k <= Depth) m = k;
      else if (k <= 3 * Depth) m = 2 * Depth - k;
      else m = k - 4 * Depth;
      um = (m < 0) ? -m : m;
      x = (HALF_PI_Q30 * um + 64'(Depth / 2)) / 64'(Depth);
      x2 = (x * x) >> 30;
      term = x;
      s = x;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2) s -= term;
        else s += term;
      end
      if (s < 0) s = 0;
      if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
      mag = ($unsigned(s) * $unsigned(SampleMax) + (64'd1 << 29)) >> 30;
      sine_lut[i] = (m < 0) ? -longint'(mag) : longint'(mag);
    end
  end

  // Expected sample for one phase word: four taps, Horner with round half up, saturate
  function automatic logic signed [SmpWidth-1:0] cubic_sine(input logic [PhWidth-1:0] ph);
    int unsigned idx;
    longint      t;
    longint      v0, v1, v2, v3;
    longint      p, q, r, h, res;
    idx = ph[PhWidth-1 -: IdxWidth];
    t   = ph[PhWidth-1-IdxWidth -: FracWidth];
    v0  = sine_lut[(idx + Depth - 1) % Depth];
    v1  = sine_lut[idx];
    v2  = sine_lut[(idx + 1) % Depth];
    v3  = sine_lut[(idx + 2) % Depth];
    p   = (v3 - v2) - (v0 - v1);
    q   = (v0 - v1) - p;
    r   = v2 - v0;
    h   = p * 65536;
    h   = ((h * t + 32768) >>> 16) + q * 65536;
    h   = ((h * t + 32768) >>> 16) + r * 65536;
    h   = ((h * t + 32768) >>> 16) + v1 * 65536;
    res = (h + 32768) >>> 16;
    if (res > SampleMax) res = SampleMax;
    if (res < SampleMin) res = SampleMin;
    return res[SmpWidth-1:0];
  endfunction

  // One transaction: idle cycles at random, then hold start until the core takes it
  task automatic send_phase(input logic [PhWidth-1:0] ph);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    phase_i <= ph;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_samples.push_back(cubic_sine(ph));
  endtask

  // Result checker: every strobe must match the oldest pending sample
  always @(posedge clk_i) begin : check_samples
    logic signed [SmpWidth-1:0] want;
    if (rst_ni && valid_o) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample, actual %0d", $time, sample_o);
        mismatch_count++;
      end else begin
        want = expected_samples.pop_front();
        if (sample_o !== want) begin
          $display("%0t: sample mismatch, expected %0d actual %0d", $time, want, sample_o);
          mismatch_count++;
        end
      end
    end
  end

  // Field extremes, quarter points, index wrap on both ends, fraction edges
  task automatic test_phase_extremes();
    send_phase(32'h0000_0000);
    send_phase(32'hFFFF_FFFF);
    send_phase(32'h8000_0000);
    send_phase(32'h4000_0000);
    send_phase(32'hC000_0000);
    send_phase(32'h001F_FFFF);  // index 0, previous tap wraps to the top
    send_phase(32'hFFE0_0000);  // last index, both upper taps wrap
    send_phase(32'hFFDF_FFFF);  // next to last index, top tap wraps
    send_phase(32'h0000_0020);  // smallest nonzero fraction
    send_phase(32'h0000_001F);  // bits below the fraction are dropped
    send_phase(32'h0010_0000);  // fraction one half
  endtask

  // Around both peaks, where the cubic may overshoot and saturate
  task automatic test_peak_saturation();
    int unsigned peak_idx [4] = '{511, 512, 1535, 1536};
    for (int i = 0; i < 4; i++) begin
      send_phase({peak_idx[i][IdxWidth-1:0], 16'h4000, 5'h00});
      send_phase({peak_idx[i][IdxWidth-1:0], 16'hC000, 5'h1F});
    end
  endtask

  // Random stream: mostly uniform, some near wrap/peaks, some oscillator-like sweeps
  task automatic test_random_phases(input int count);
    int unsigned     sel;
    int unsigned     hot_idx [10] = '{0, 1, 2046, 2047, 511, 512, 513, 1535, 1536, 1537};
    logic [PhWidth-1:0] acc;
    logic [PhWidth-1:0] ph;
    logic [PhWidth-1:0] step;
    acc  = $urandom;
    step = $urandom_range(1, 32'h00FF_FFFF);
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 3) && (i < count / 2);
      sel = $urandom_range(9);
      if (sel < 6) begin
        ph = $urandom;
      end else if (sel < 8) begin
        ph = $urandom;
        ph[PhWidth-1 -: IdxWidth] = IdxWidth'(hot_idx[$urandom_range(9)]);
      end else begin
        if ($urandom_range(31) == 0) step = $urandom;
        acc = acc + step;
        ph  = acc;
      end
      send_phase(ph);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_phase_extremes();
    test_peak_saturation();
    test_random_phases(1500);
    start <= 1'b0;
    // drain the pipeline
    for (int w = 0; w < 100 && expected_samples.size() != 0; w++) @(posedge clk_i);
    if (expected_samples.size() != 0) begin
      $display("%0t: %0d samples never arrived", $time, expected_samples.size());
      mismatch_count++;
    end
    repeat (Latency + 3) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
